### rtl/dbm_hash_directory_lookup_top_defines.svh
// Assertion macros for the dbm hash directory lookup block.
`ifndef DBM_HASH_DIRECTORY_LOOKUP_TOP_DEFINES_SVH
`define DBM_HASH_DIRECTORY_LOOKUP_TOP_DEFINES_SVH

// same-cycle implication
`define DBM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DBM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dbm_hdl_pkg.sv
// Shared types, constants and hash tables of the dbm hash directory lookup.
`timescale 1ns / 1ps
package dbm_hdl_pkg;

  localparam int unsigned DIR_BITS_DEF = 4096;
  localparam int unsigned HASH_W       = 32;
  localparam int unsigned MASK_W       = 12;
  localparam int unsigned BIT_W        = 13;
  localparam int unsigned STEP_W       = 6;
  localparam int unsigned NIB_W        = 4;

  localparam logic [MASK_W-1:0] MASK_LIMIT = '1;

  typedef enum logic [1:0] {
    OP_KEY_BYTE = 2'd0,
    OP_LOOKUP   = 2'd1,
    OP_SPLIT    = 2'd2
  } dbm_op_e;

  typedef enum logic [1:0] {
    ST_LOOKUP_DONE   = 2'd0,
    ST_SPLIT_SET     = 2'd1,
    ST_SPLIT_REFUSED = 2'd2
  } dbm_status_e;

  typedef struct packed {
    logic               valid;
    logic [HASH_W-1:0]  key_hash;
    logic [MASK_W-1:0]  block_number;
    logic [MASK_W-1:0]  level_mask;
    dbm_status_e        status;
  } dbm_res_t;

  localparam logic [STEP_W-1:0] STEP_TABLE [16] = '{
    6'd61, 6'd57, 6'd53, 6'd49, 6'd45, 6'd41, 6'd37, 6'd33,
    6'd29, 6'd25, 6'd21, 6'd17, 6'd13, 6'd9,  6'd5,  6'd1
  };

  localparam logic [HASH_W-1:0] ADD_TABLE [64] = '{
    32'o6100151277, 32'o6106161736, 32'o6452611562, 32'o5001724107,
    32'o2614772546, 32'o4120731531, 32'o4665262210, 32'o7347467531,
    32'o6735253126, 32'o6042345173, 32'o3072226605, 32'o1464164730,
    32'o3247435524, 32'o7652510057, 32'o1546775256, 32'o5714532133,
    32'o6173260402, 32'o7517101630, 32'o2431460343, 32'o1743245566,
    32'o0261675137, 32'o2433103631, 32'o3421772437, 32'o4447707466,
    32'o4435620103, 32'o3757017115, 32'o3641531772, 32'o6767633246,
    32'o2673230344, 32'o0260612216, 32'o4133454451, 32'o0615531516,
    32'o6137717526, 32'o2574116560, 32'o2304023373, 32'o7061702261,
    32'o5153031405, 32'o5322056705, 32'o7401116734, 32'o6552375715,
    32'o6165233473, 32'o5311063631, 32'o1212221723, 32'o1052267235,
    32'o6000615237, 32'o1075222665, 32'o6330216006, 32'o4402355630,
    32'o1451177262, 32'o2000133436, 32'o6025467062, 32'o7121076461,
    32'o3123433522, 32'o1010635225, 32'o1716177066, 32'o5161746527,
    32'o1736635071, 32'o6243505026, 32'o3637211610, 32'o1756474365,
    32'o4723077174, 32'o3642763134, 32'o5750130273, 32'o3655541561
  };

endpackage

### rtl/dbm_hdl_hash.sv
// Key hash accumulator: one nibble per cycle through the step and add tables.
`timescale 1ns / 1ps
module dbm_hdl_hash
  import dbm_hdl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [7:0]        key_byte_i,
  input  logic              clear_i,
  output logic              busy_o,
  output logic [HASH_W-1:0] hash_o
);

  logic              busy_q;
  logic [NIB_W-1:0]  hi_q;
  logic [STEP_W-1:0] step_q;
  logic [HASH_W-1:0] hash_q;
  logic [NIB_W-1:0]  nib;
  logic [STEP_W-1:0] step_d;
  logic [HASH_W-1:0] hash_d;

  assign nib    = busy_q ? hi_q : key_byte_i[NIB_W-1:0];
  assign step_d = step_q + STEP_TABLE[nib];
  assign hash_d = hash_q + ADD_TABLE[step_d];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      hi_q   <= '0;
      step_q <= '0;
      hash_q <= '0;
    end else begin
      busy_q <= start_i;
      if (start_i) begin
        hi_q <= key_byte_i[7:NIB_W];
      end
      if (clear_i) begin
        step_q <= '0;
        hash_q <= '0;
      end else if (start_i || busy_q) begin
        step_q <= step_d;
        hash_q <= hash_d;
      end
    end
  end

  assign busy_o = busy_q;
  assign hash_o = hash_q;

endmodule

### rtl/dbm_hdl_dir.sv
// Split-bit directory memory with clearing pass, level walk and split marking.
`timescale 1ns / 1ps
module dbm_hdl_dir
  import dbm_hdl_pkg::*;
#(
  parameter int unsigned DIR_BITS = DIR_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              lookup_i,
  input  logic              split_i,
  input  logic              read_only_i,
  input  logic [HASH_W-1:0] hash_i,
  input  logic              res_ready_i,
  output logic              busy_o,
  output dbm_res_t          res_o
);

  localparam int unsigned AW = $clog2(DIR_BITS);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_DONE
  } state_e;

  state_e            state_q;
  logic [AW-1:0]     clr_cnt_q;
  logic [HASH_W-1:0] hash_q;
  logic [MASK_W-1:0] mask_q;
  logic [MASK_W-1:0] block_q;
  logic [BIT_W-1:0]  bit_q;
  logic              in_range_q;
  logic [BIT_W-1:0]  last_bit_q;
  dbm_status_e       status_q;

  logic              mem_q [DIR_BITS];
  logic              rd_q;

  logic [MASK_W-1:0] mask_d;
  logic [BIT_W-1:0]  bit_d;
  logic              in_range_d;
  logic              last_in_range;
  logic              walk_stop;
  logic              split_ok;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              wr_data;

  assign mask_d        = {mask_q[MASK_W-2:0], 1'b1};
  assign bit_d         = BIT_W'(hash_q[MASK_W-1:0] & mask_d) + BIT_W'(mask_d);
  assign in_range_d    = 32'(bit_d) < 32'(DIR_BITS);
  assign last_in_range = 32'(last_bit_q) < 32'(DIR_BITS);
  assign walk_stop     = !(rd_q && in_range_q) || (mask_q == MASK_LIMIT);
  assign split_ok      = !read_only_i && last_in_range;

  assign rd_addr = (state_q == S_IDLE) ? '0 : AW'(bit_d);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(last_bit_q);
    wr_data = 1'b1;
    if (state_q == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q;
      wr_data = 1'b0;
    end else if (state_q == S_IDLE && split_i && !lookup_i && split_ok) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_cnt_q  <= '0;
      last_bit_q <= '0;
      hash_q     <= '0;
      mask_q     <= '0;
      block_q    <= '0;
      bit_q      <= '0;
      in_range_q <= 1'b0;
      status_q   <= ST_LOOKUP_DONE;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == AW'(DIR_BITS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (lookup_i) begin
            hash_q     <= hash_i;
            mask_q     <= '0;
            bit_q      <= '0;
            in_range_q <= 1'b1;
            state_q    <= S_WALK;
          end else if (split_i) begin
            hash_q   <= '0;
            mask_q   <= '0;
            block_q  <= '0;
            status_q <= split_ok ? ST_SPLIT_SET : ST_SPLIT_REFUSED;
            state_q  <= S_DONE;
          end
        end
        S_WALK: begin
          if (walk_stop) begin
            last_bit_q <= bit_q;
            block_q    <= hash_q[MASK_W-1:0] & mask_q;
            status_q   <= ST_LOOKUP_DONE;
            state_q    <= S_DONE;
          end else begin
            mask_q     <= mask_d;
            bit_q      <= bit_d;
            in_range_q <= in_range_d;
          end
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign busy_o             = (state_q != S_IDLE);
  assign res_o.valid        = (state_q == S_DONE);
  assign res_o.key_hash     = hash_q;
  assign res_o.block_number = block_q;
  assign res_o.level_mask   = mask_q;
  assign res_o.status       = status_q;

endmodule

### rtl/dbm_hash_directory_lookup_top.sv
// Key byte: one nibble per cycle through the step and add tables, no result.
// Lookup: a walk of L levels (1..13), one directory read per level.
// Split: one directory write. A done result is registered once the output is free.
// After reset a clearing pass clears the DIR_BITS directory bits, one per cycle,
// and no beat is taken until it ends; configuration writes are taken throughout.
// Reset: asynchronous, active low; hash, step, last bit index and read_only clear.
`timescale 1ns / 1ps
`include "dbm_hash_directory_lookup_top_defines.svh"
module dbm_hash_directory_lookup_top
  import dbm_hdl_pkg::*;
#(
  parameter int unsigned DIR_BITS = DIR_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        operation_i,
  input  logic [7:0]        key_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [HASH_W-1:0] key_hash_o,
  output logic [MASK_W-1:0] block_number_o,
  output logic [MASK_W-1:0] level_mask_o,
  output logic [1:0]        status_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i
);

  logic              read_only_q;
  logic              in_acc;
  logic              key_start;
  logic              lookup_start;
  logic              split_start;
  logic              hash_busy;
  logic [HASH_W-1:0] hash_sum;
  logic              dir_busy;
  dbm_res_t          dir_res;
  logic              res_ready;

  logic              out_valid_q;
  logic [HASH_W-1:0] key_hash_q;
  logic [MASK_W-1:0] block_number_q;
  logic [MASK_W-1:0] level_mask_q;
  dbm_status_e       status_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = hash_busy || dir_busy;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign res_ready   = !out_valid_q || !out_stall_i;

  always_comb begin
    key_start    = 1'b0;
    lookup_start = 1'b0;
    split_start  = 1'b0;
    if (in_acc) begin
      unique case (operation_i)
        OP_KEY_BYTE: key_start    = 1'b1;
        OP_LOOKUP:   lookup_start = 1'b1;
        OP_SPLIT:    split_start  = 1'b1;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_only_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      read_only_q <= cfg_data_i;
    end
  end

  dbm_hdl_hash u_hash (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (key_start),
    .key_byte_i (key_byte_i),
    .clear_i    (lookup_start),
    .busy_o     (hash_busy),
    .hash_o     (hash_sum)
  );

  dbm_hdl_dir #(
    .DIR_BITS (DIR_BITS)
  ) u_dir (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lookup_i    (lookup_start),
    .split_i     (split_start),
    .read_only_i (read_only_q),
    .hash_i      (hash_sum),
    .res_ready_i (res_ready),
    .busy_o      (dir_busy),
    .res_o       (dir_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= dir_res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && dir_res.valid) begin
      key_hash_q     <= dir_res.key_hash;
      block_number_q <= dir_res.block_number;
      level_mask_q   <= dir_res.level_mask;
      status_q       <= dir_res.status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign key_hash_o     = key_hash_q;
  assign block_number_o = block_number_q;
  assign level_mask_o   = level_mask_q;
  assign status_o       = status_q;

  `DBM_ASSERT_NXT(a_lookup_clears_hash, lookup_start, hash_sum == '0, "hash not cleared")
  `DBM_ASSERT_NXT(a_lookup_starts_walk, lookup_start, dir_busy, "walk did not start")
  `DBM_ASSERT_IMP(a_out_from_result, $rose(out_valid_q), $past(dir_res.valid), "stray beat")
  `DBM_ASSERT_NXT(a_result_moves, dir_res.valid && !out_valid_q, out_valid_q, "result lost")

endmodule
